[rtl/hfd_pkg.sv]
package hfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int TEMP_W   = 15;
   localparam int HUM_W    = 14;
   localparam int STATUS_W = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // scale factors in hundredths, full scale is 2^16 - 1
   localparam int TEMP_SCALE  = 17500;
   localparam int TEMP_OFFSET = 4500;
   localparam int HUM_SCALE   = 10000;

   localparam int TEMP_MIN_CENTI = -4500;
   localparam int TEMP_MAX_CENTI = 13000;
   localparam int HUM_MAX_CENTI  = 10000;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TEMP_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HUM_BAD  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BOTH_BAD = 2'd3;

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

[rtl/hfd_scale.sv]
module hfd_scale (
   input  logic [hfd_pkg::WORD_W-1:0]        temp_word,
   input  logic [hfd_pkg::WORD_W-1:0]        hum_word,
   output logic signed [hfd_pkg::TEMP_W-1:0] temperature_centi,
   output logic [hfd_pkg::HUM_W-1:0]         humidity_centi
);
   import hfd_pkg::*;

   // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 2^16
   logic [30:0] t_prod;
   logic [31:0] t_sum;
   logic [15:0] t_quo;
   logic [29:0] h_prod;
   logic [30:0] h_sum;
   logic [15:0] t_diff;

   assign t_prod = 31'(TEMP_SCALE) * {15'd0, temp_word};
   assign t_sum  = {1'b0, t_prod} + {17'd0, t_prod[30:16]} + 32'd1;
   assign t_quo  = t_sum[31:16];
   assign t_diff = t_quo - 16'(TEMP_OFFSET);
   assign temperature_centi = t_diff[TEMP_W-1:0];

   assign h_prod = 30'(HUM_SCALE) * {14'd0, hum_word};
   assign h_sum  = {1'b0, h_prod} + {17'd0, h_prod[29:16]} + 31'd1;
   assign humidity_centi = h_sum[16+HUM_W-1:16];

endmodule

[rtl/humidity_temp_frame_decoder_top.sv]
// Decodes a six-byte temperature/humidity sensor reply (temperature word,
// CRC-8, humidity word, CRC-8, words high byte first) taken one byte per
// item, and emits one item after the sixth byte: temperature and humidity
// in hundredths, with a CRC status; both values are zero when a CRC fails.
// req_frame_start marks the first byte and resynchronizes. One byte is
// taken every cycle while req_stall is low; the result is set by the
// result register and appears in the cycle after the sixth byte is taken.
// req_stall rises only while a result is held and rsp_stall is high.
module humidity_temp_frame_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hfd_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [hfd_pkg::TEMP_W-1:0] rsp_temperature_centi,
   output logic [hfd_pkg::HUM_W-1:0]         rsp_humidity_centi,
   output logic [hfd_pkg::STATUS_W-1:0]      rsp_status
);
   import hfd_pkg::*;

   typedef enum logic [5:0] {
      ST_T_HI  = 6'b000001,
      ST_T_LO  = 6'b000010,
      ST_T_CRC = 6'b000100,
      ST_H_HI  = 6'b001000,
      ST_H_LO  = 6'b010000,
      ST_H_CRC = 6'b100000
   } byte_state_type;

   byte_state_type        state_ff, state_in, cur_state;
   logic [BYTE_W-1:0]     crc_ff, crc_in;
   logic [WORD_W-1:0]     temp_word_ff, temp_word_in;
   logic [WORD_W-1:0]     hum_word_ff, hum_word_in;
   logic                  temp_bad_ff, temp_bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [HUM_W-1:0]      hum_ff, hum_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  accept;
   logic                  emit;
   logic                  hum_bad;
   logic signed [TEMP_W-1:0] scaled_temp;
   logic [HUM_W-1:0]      scaled_hum;

   hfd_scale u_scale (
      .temp_word         (temp_word_ff),
      .hum_word          (hum_word_ff),
      .temperature_centi (scaled_temp),
      .humidity_centi    (scaled_hum)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign cur_state = req_frame_start ? ST_T_HI : state_ff;
   assign hum_bad   = (crc_ff != req_rx_byte);

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_bad_in  = temp_bad_ff;
      emit         = 1'b0;
      if (accept) begin
         case (cur_state)
            ST_T_LO: begin
               crc_in       = crc8_byte(crc_ff, req_rx_byte);
               temp_word_in = {temp_word_ff[WORD_W-1:BYTE_W], req_rx_byte};
               state_in     = ST_T_CRC;
            end
            ST_T_CRC: begin
               temp_bad_in = (crc_ff != req_rx_byte);
               crc_in      = CRC_INIT;
               state_in    = ST_H_HI;
            end
            ST_H_HI: begin
               crc_in      = crc8_byte(CRC_INIT, req_rx_byte);
               hum_word_in = {req_rx_byte, hum_word_ff[BYTE_W-1:0]};
               state_in    = ST_H_LO;
            end
            ST_H_LO: begin
               crc_in      = crc8_byte(crc_ff, req_rx_byte);
               hum_word_in = {hum_word_ff[WORD_W-1:BYTE_W], req_rx_byte};
               state_in    = ST_H_CRC;
            end
            ST_H_CRC: begin
               emit     = 1'b1;
               crc_in   = CRC_INIT;
               state_in = ST_T_HI;
            end
            default: begin
               crc_in       = crc8_byte(CRC_INIT, req_rx_byte);
               temp_word_in = {req_rx_byte, temp_word_ff[BYTE_W-1:0]};
               state_in     = ST_T_LO;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      status_in    = status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         status_in    = {hum_bad, temp_bad_ff};
         if (status_in == STATUS_OK) begin
            temp_in = scaled_temp;
            hum_in  = scaled_hum;
         end else begin
            temp_in = '0;
            hum_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_T_HI;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         temp_bad_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_bad_ff  <= temp_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff      <= temp_in;
      hum_ff       <= hum_in;
      status_ff    <= status_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_status            = status_ff;

endmodule

[rtl/hfd_checker.sv]
module hfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [hfd_pkg::TEMP_W-1:0] rsp_temperature_centi,
   input logic [hfd_pkg::HUM_W-1:0]         rsp_humidity_centi,
   input logic [hfd_pkg::STATUS_W-1:0]      rsp_status
);
   import hfd_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature_centi)
         && $stable(rsp_humidity_centi) && $stable(rsp_status))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_new_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without an accepted item");

   a_crc_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_temperature_centi == '0 && rsp_humidity_centi == '0)
      else $error("nonzero values on CRC error");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_temperature_centi >= TEMP_W'(TEMP_MIN_CENTI)
         && rsp_temperature_centi <= TEMP_W'(TEMP_MAX_CENTI)
         && rsp_humidity_centi <= HUM_W'(HUM_MAX_CENTI))
      else $error("value out of range");

endmodule

bind humidity_temp_frame_decoder_top hfd_checker u_hfd_checker (.*);
